/* hw/rtl/r2fft_pkg.sv */
`default_nettype none
package r2fft_pkg;
  localparam int MAX_POINTS_DEF   = 64;
  localparam int TWIDDLE_BITS_DEF = 16;
  localparam int DATA_W  = 24;
  localparam int SAMP_W  = 16;
  localparam int IDX_W   = 6;
  localparam int LOG_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE  = 1'b1;
  localparam logic signed [DATA_W-1:0] DATA_MAX = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN = -24'sh800000;

  // Controller to datapath commands.
  typedef struct packed {
    logic                 load;      // write an input item
    logic [IDX_W-1:0]     load_addr; // bit-reversed address
    logic                 rd;        // operand read cycle; latches the twiddle
    logic [IDX_W-1:0]     addr_a;
    logic [IDX_W-1:0]     addr_b;
    logic [4:0]           tw_idx;
    logic                 bfly_wr;   // write back the butterfly results
    logic [IDX_W-1:0]     wr_a;
    logic [IDX_W-1:0]     wr_b;
    logic                 out_rd;    // read a bin for output
    logic [IDX_W-1:0]     out_addr;
  } ctrl_cmd_t;

  // Quarter-wave sine, Q1.23.
  function automatic logic [23:0] quarter_sine(input logic [4:0] k);
    logic [23:0] v;
    case (k)
      5'd0:  v = 24'd0;       5'd1:  v = 24'd822227;
      5'd2:  v = 24'd1636536; 5'd3:  v = 24'd2435084;
      5'd4:  v = 24'd3210181; 5'd5:  v = 24'd3954362;
      5'd6:  v = 24'd4660461; 5'd7:  v = 24'd5321677;
      5'd8:  v = 24'd5931642; 5'd9:  v = 24'd6484482;
      5'd10: v = 24'd6974873; 5'd11: v = 24'd7398092;
      5'd12: v = 24'd7750063; 5'd13: v = 24'd8027397;
      5'd14: v = 24'd8227423; 5'd15: v = 24'd8348215;
      5'd16: v = 24'd8388608;
      default: v = 24'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/r2fft_if.sv */
`default_nettype none
interface r2fft_in_if;
  logic valid;
  logic ready;
  logic signed [r2fft_pkg::SAMP_W-1:0] sample_real;
  logic signed [r2fft_pkg::SAMP_W-1:0] sample_imag;
  modport source (output valid, sample_real, sample_imag, input ready);
  modport sink (input valid, sample_real, sample_imag, output ready);
endinterface

interface r2fft_out_if;
  logic valid;
  logic ready;
  logic signed [r2fft_pkg::DATA_W-1:0] bin_real;
  logic signed [r2fft_pkg::DATA_W-1:0] bin_imag;
  logic [r2fft_pkg::IDX_W-1:0] bin_index;
  logic last_bin;
  modport source (output valid, bin_real, bin_imag, bin_index, last_bin, input ready);
  modport sink (input valid, bin_real, bin_imag, bin_index, last_bin, output ready);
endinterface
`default_nettype wire

/* hw/rtl/radix2_fft_frame_top.sv */
`default_nettype none
// An n-point frame first takes n input items, then runs (n/2)*log2(n) butterflies
// and one read before the first bin; bins then leave one per cycle while out_ready is high.
// One butterfly unit reads both operands from a dual-bank frame memory and finishes
// each butterfly, mirror write included, before the next one starts.
// Reset (rst_n, synchronous): log_size 6, inverse off, empty frame.
module radix2_fft_frame_top #(
  parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
  parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
  input  wire clk,
  input  wire rst_n,
  r2fft_in_if.sink    in_ch,
  r2fft_out_if.source out_ch,
  input  wire                                cfg_we,
  input  wire [r2fft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [r2fft_pkg::CFG_DATA_W-1:0]    cfg_data
);
  // The largest usable log length follows from MAX_POINTS.
  localparam int LIM = (MAX_POINTS >= 64) ? 6 : $clog2(MAX_POINTS + 1) - 1;

  logic [r2fft_pkg::LOG_W-1:0] log_size_r, lg;
  logic inverse_r;
  logic clr;
  r2fft_pkg::ctrl_cmd_t cmd;

  // Configuration registers. A size write drops the partial frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_size_r <= 3'd6;
      inverse_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        r2fft_pkg::REG_LOG_SIZE: log_size_r <= cfg_data;
        r2fft_pkg::REG_INVERSE:  inverse_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign clr = cfg_we && (cfg_index == r2fft_pkg::REG_LOG_SIZE);
  assign lg  = (log_size_r > 3'(LIM)) ? 3'(LIM) : log_size_r;

  r2fft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .lg(lg), .clr_frame(clr),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_index(out_ch.bin_index), .out_last(out_ch.last_bin), .cmd(cmd)
  );

  r2fft_datapath #(.MAX_POINTS(MAX_POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_dp (
    .clk(clk), .cmd(cmd), .inv(inverse_r), .lg(lg),
    .in_re(in_ch.sample_real), .in_im(in_ch.sample_imag),
    .bin_re(out_ch.bin_real), .bin_im(out_ch.bin_imag)
  );

`ifndef ASSERT_OFF
  // No input is taken while bins are being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("input and output overlap");
  // After the last bin is taken the block is ready to load again.
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_bin |=> in_ch.ready)
    else $error("frame did not return to load");
  // A stalled bin keeps its index.
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.bin_index))
    else $error("bin index moved under stall");
`endif
endmodule
`default_nettype wire

/* hw/rtl/r2fft_datapath.sv */
`default_nettype none
module r2fft_datapath #(
  parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
  parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
  input  wire                              clk,
  input  wire r2fft_pkg::ctrl_cmd_t        cmd,
  input  wire                              inv,
  input  wire [r2fft_pkg::LOG_W-1:0]       lg,
  input  wire signed [r2fft_pkg::SAMP_W-1:0] in_re,
  input  wire signed [r2fft_pkg::SAMP_W-1:0] in_im,
  output logic signed [r2fft_pkg::DATA_W-1:0] bin_re,
  output logic signed [r2fft_pkg::DATA_W-1:0] bin_im
);
  localparam int DW = r2fft_pkg::DATA_W;
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int TW = TWIDDLE_BITS;
  localparam int SH = 24 - TW;
  localparam int PW = DW + TW + 1;

  // Two banks hold the same data so both operands read in the same cycle.
  logic [2*DW-1:0] mem_a [MAX_POINTS];
  logic [2*DW-1:0] mem_b [MAX_POINTS];
  logic [2*DW-1:0] rd_a_r, rd_b_r;

  // Twiddle parts carry one extra bit because a part can reach exactly +1.0.
  logic signed [TW:0]   wr_tw, wi_tw, wr_r, wi_r;
  logic signed [DW-1:0] ur_r, ui_r, vr_r, vi_r;
  logic signed [PW:0]   pr, pi;
  logic signed [DW+1:0] tr, ti, br, bi;
  logic [2*DW-1:0]      top_w, bot_w, ld_w;

  // Writes at a and b land in opposite banks; mirror copies keep banks equal.
  logic             mir_v_r;
  logic [AW-1:0]    mir_a_r, mir_b_r;
  logic [2*DW-1:0]  mir_top_r, mir_bot_r;

  function automatic logic signed [TW:0] rnd(input logic [23:0] v);
    logic [24:0] s;
    s = {1'b0, v};
    if (SH > 0) s = s + (25'd1 << (SH - 1));
    return (TW+1)'(s >> SH);
  endfunction

  function automatic logic signed [DW-1:0] sat(input logic signed [DW+1:0] x);
    if (x > DW'(r2fft_pkg::DATA_MAX)) return r2fft_pkg::DATA_MAX;
    if (x < (DW+2)'(r2fft_pkg::DATA_MIN)) return r2fft_pkg::DATA_MIN;
    return x[DW-1:0];
  endfunction

  always_comb begin
    logic [4:0] t;
    logic signed [TW:0] c, s;
    t = cmd.tw_idx;
    if (t <= 5'd16) begin
      c = rnd(r2fft_pkg::quarter_sine(5'd16 - t));
      s = rnd(r2fft_pkg::quarter_sine(t));
    end else begin
      c = -rnd(r2fft_pkg::quarter_sine(t - 5'd16));
      s = rnd(r2fft_pkg::quarter_sine(5'd0 - t));
    end
    wr_tw = c;
    wi_tw = inv ? s : -s;
  end

  assign ld_w = {DW'(in_re), DW'(in_im)};

  // Stage 1: read operands. Stage 2: multiply and butterfly, write back.
  // The mirror write lands in the cycle after the butterfly write.
  always_ff @(posedge clk) begin
    mir_v_r   <= cmd.bfly_wr;
    mir_a_r   <= cmd.wr_a[AW-1:0];
    mir_b_r   <= cmd.wr_b[AW-1:0];
    mir_top_r <= top_w;
    mir_bot_r <= bot_w;
    if (cmd.load) begin
      mem_a[cmd.load_addr[AW-1:0]] <= ld_w;
      mem_b[cmd.load_addr[AW-1:0]] <= ld_w;
    end else if (cmd.bfly_wr) begin
      mem_a[cmd.wr_a[AW-1:0]] <= top_w;
      mem_b[cmd.wr_b[AW-1:0]] <= bot_w;
    end else if (mir_v_r) begin
      mem_b[mir_a_r] <= mir_top_r;
      mem_a[mir_b_r] <= mir_bot_r;
    end
    rd_a_r <= mem_a[cmd.out_rd ? cmd.out_addr[AW-1:0] : cmd.addr_a[AW-1:0]];
    rd_b_r <= mem_b[cmd.addr_b[AW-1:0]];
    if (cmd.rd) begin
      wr_r <= wr_tw;
      wi_r <= wi_tw;
    end
  end

  always_comb begin
    logic signed [DW-1:0] xr, xi, ar, ai;
    logic signed [PW:0] h;
    ar = rd_a_r[2*DW-1:DW];
    ai = rd_a_r[DW-1:0];
    xr = rd_b_r[2*DW-1:DW];
    xi = rd_b_r[DW-1:0];
    h  = (PW+1)'(1) <<< (TW - 2);
    pr = (xr * wr_r) - (xi * wi_r) + h;
    pi = (xr * wi_r) + (xi * wr_r) + h;
    ur_r = ar; ui_r = ai;
    vr_r = DW'(pr >>> (TW - 1));
    vi_r = DW'(pi >>> (TW - 1));
    tr = ur_r + vr_r; ti = ui_r + vi_r;
    br = ur_r - vr_r; bi = ui_r - vi_r;
    top_w = {sat(tr), sat(ti)};
    bot_w = {sat(br), sat(bi)};
  end

  // Output: optional inverse scaling with rounding.
  always_comb begin
    logic signed [DW:0] r, xr, xi;
    r  = (lg == '0) ? '0 : ((DW+1)'(1) <<< (lg - 1'b1));
    xr = (DW+1)'(signed'(rd_a_r[2*DW-1:DW]));
    xi = (DW+1)'(signed'(rd_a_r[DW-1:0]));
    if (inv) begin
      bin_re = DW'((xr + r) >>> lg);
      bin_im = DW'((xi + r) >>> lg);
    end else begin
      bin_re = rd_a_r[2*DW-1:DW];
      bin_im = rd_a_r[DW-1:0];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/r2fft_ctrl.sv */
`default_nettype none
module r2fft_ctrl #(
  parameter int MAX_POINTS = r2fft_pkg::MAX_POINTS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [r2fft_pkg::LOG_W-1:0]   lg,
  input  wire                          clr_frame,
  input  wire                          in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [r2fft_pkg::IDX_W-1:0]  out_index,
  output logic                         out_last,
  output r2fft_pkg::ctrl_cmd_t         cmd
);
  localparam int IW = r2fft_pkg::IDX_W;
  localparam logic [2:0] ST_LOAD = 3'd0, ST_BFLY = 3'd1, ST_GAP = 3'd2,
                         ST_OREQ = 3'd3, ST_OUT = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic [IW:0]  cnt_r, cnt_nxt;      // load count or output index
  logic [2:0]   stg_r, stg_nxt;      // stage 1..lg
  logic [IW-1:0] bf_r, bf_nxt;       // butterfly number in stage
  logic [1:0]   gap_r, gap_nxt;
  logic [IW:0]  n;
  logic [IW-1:0] rev, kk, hlf, start, a;
  logic         acc;

  assign n = (IW+1)'(1) << lg;

  always_comb begin
    rev = '0;
    for (int b = 0; b < IW; b++)
      if (b < int'(lg)) rev[int'(lg) - 1 - b] = cnt_r[b];
  end

  always_comb begin
    hlf   = IW'(1) << (stg_r - 3'd1);
    kk    = bf_r & (hlf - 1'b1);
    start = (bf_r & ~(hlf - 1'b1)) << 1;
    a     = start | kk;
  end

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_OUT);
  assign out_index = cnt_r[IW-1:0];
  assign out_last  = (cnt_r == n - 1'b1);
  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; stg_nxt = stg_r;
    bf_nxt = bf_r; gap_nxt = gap_r;
    cmd = '0;
    cmd.load_addr = rev;
    cmd.addr_a = a; cmd.addr_b = a + hlf;
    cmd.tw_idx = 5'(kk << (3'd6 - stg_r));
    cmd.out_addr = cnt_r[IW-1:0];
    case (state_r)
      ST_LOAD: begin
        if (clr_frame) cnt_nxt = '0;
        else if (acc) begin
          cmd.load = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r + 1'b1 >= n) begin
            cnt_nxt = '0; stg_nxt = 3'd1; bf_nxt = '0;
            state_nxt = (lg == '0) ? ST_OREQ : ST_BFLY;
          end
        end
      end
      ST_BFLY: begin
        // One butterfly in flight: read, then compute and write.
        cmd.rd = 1'b1;
        gap_nxt = 2'd0;
        state_nxt = ST_GAP;
      end
      ST_GAP: begin
        gap_nxt = gap_r + 1'b1;
        if (gap_r == 2'd1) begin
          cmd.bfly_wr = 1'b1;
          cmd.wr_a = a; cmd.wr_b = a + hlf;
          cmd.tw_idx = 5'(kk << (3'd6 - stg_r));
        end
        if (gap_r == 2'd2) begin
          // Mirror write lands with this edge, before the next read.
          state_nxt = ST_BFLY;
          if ((IW+1)'(bf_r) + 1'b1 >= (n >> 1)) begin
            bf_nxt = '0;
            if (stg_r == lg) state_nxt = ST_OREQ;
            else stg_nxt = stg_r + 1'b1;
          end else bf_nxt = bf_r + 1'b1;
        end
      end
      ST_OREQ: begin
        cmd.out_rd = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Keep the read port on the current bin so a stalled bin holds.
        cmd.out_rd = 1'b1;
        if (out_ready) begin
          if (out_last) begin
            cnt_nxt = '0; state_nxt = ST_LOAD;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            cmd.out_addr = IW'(cnt_r + 1'b1);
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; cnt_r <= '0; stg_r <= 3'd1; bf_r <= '0; gap_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; stg_r <= stg_nxt;
      bf_r <= bf_nxt; gap_r <= gap_nxt;
    end
  end
endmodule
`default_nettype wire
